### rtl/pli_pkg.sv
// Package with the shared types and codes of the piecewise linear interpolator.
package pli_pkg;

  // Default capacity of the point table.
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_FEW   = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] y_result;
    logic               exact_hit;
  } result_t;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic signed [31:0] x;        // query x, or the point being inserted
    logic signed [31:0] y;
    logic               pending;  // insert point not yet placed
    logic               modify;   // table has room, the insert may write
    logic               found;    // duplicate x on insert, exact hit on query
    logic signed [31:0] fy;       // stored y of an exact hit
    logic signed [31:0] ax;       // lower point of the chosen segment
    logic signed [31:0] ay;
    logic signed [31:0] bx;       // upper point of the chosen segment
    logic signed [31:0] by;
    logic [1:0]         seen;     // valid cells passed, saturating at two
    logic               locked;   // segment chosen
  } tok_t;

  // Segment and abscissa handed to the line evaluation unit.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x;
  } arith_req_t;

endpackage

### rtl/pli_cell.sv
// One table cell: holds a point and passes the token on to its neighbor.
module pli_cell (
  input  logic         clk,
  input  logic         rst,
  input  pli_pkg::tok_t tok_in,
  output pli_pkg::tok_t tok_out
);
  import pli_pkg::*;

  logic               used;
  logic signed [31:0] px;
  logic signed [31:0] py;

  tok_t               t;
  logic               used_next;
  logic signed [31:0] px_next;
  logic signed [31:0] py_next;
  logic [1:0]         seen_new;

  // Work of this cell on the passing token.
  always_comb begin
    t         = tok_in;
    used_next = used;
    px_next   = px;
    py_next   = py;
    seen_new  = (tok_in.seen == 2'd2) ? 2'd2 : tok_in.seen + 2'd1;
    if (tok_in.valid) begin
      case (tok_in.op)
        OP_CLEAR: begin
          used_next = 1'b0;
        end
        OP_INSERT: begin
          if (used && px == tok_in.x) begin
            t.found   = 1'b1;
            t.pending = 1'b0;
          end else if (tok_in.pending && tok_in.modify) begin
            if (!used) begin
              used_next = 1'b1;
              px_next   = tok_in.x;
              py_next   = tok_in.y;
              t.pending = 1'b0;
            end else if (px > tok_in.x) begin
              // Take the new point and carry the displaced one onward.
              px_next = tok_in.x;
              py_next = tok_in.y;
              t.x     = px;
              t.y     = py;
            end
          end
        end
        OP_QUERY: begin
          if (used) begin
            if (px == tok_in.x && !tok_in.found) begin
              t.found = 1'b1;
              t.fy    = py;
            end
            if (!tok_in.locked) begin
              t.ax   = tok_in.bx;
              t.ay   = tok_in.by;
              t.bx   = px;
              t.by   = py;
              t.seen = seen_new;
              if (px > tok_in.x && seen_new == 2'd2) begin
                t.locked = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell state and the token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      used          <= used_next;
      tok_out.valid <= t.valid;
    end
    px <= px_next;
    py <= py_next;
    tok_out.op      <= t.op;
    tok_out.x       <= t.x;
    tok_out.y       <= t.y;
    tok_out.pending <= t.pending;
    tok_out.modify  <= t.modify;
    tok_out.found   <= t.found;
    tok_out.fy      <= t.fy;
    tok_out.ax      <= t.ax;
    tok_out.ay      <= t.ay;
    tok_out.bx      <= t.bx;
    tok_out.by      <= t.by;
    tok_out.seen    <= t.seen;
    tok_out.locked  <= t.locked;
  end

endmodule

### rtl/pli_arith.sv
// Line evaluation unit: serial multiply, serial divide, rounding and saturation.
module pli_arith (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pli_pkg::arith_req_t req,
  output logic               done,
  output logic               sat,
  output logic signed [31:0] y
);
  import pli_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_t;

  localparam logic signed [36:0] R_MAX = 37'sd2147483647;
  localparam logic signed [36:0] R_MIN = -37'sd2147483648;

  astate_t            state;
  logic [6:0]         cnt;
  logic [63:0]        mcand;
  logic [31:0]        mplier;
  logic [64:0]        num;
  logic [31:0]        rem;
  logic [31:0]        dx;
  logic signed [31:0] y0;
  logic               neg;

  logic signed [32:0] dy_s;
  logic signed [32:0] t_s;
  logic [32:0]        dx_s;
  logic [32:0]        rem_sh;
  logic [33:0]        diff;
  logic               qbig;
  logic signed [36:0] r;

  // Operand preparation on start.
  always_comb begin
    dy_s = {req.y1[31], req.y1} - {req.y0[31], req.y0};
    t_s  = {req.x[31], req.x} - {req.x0[31], req.x0};
    dx_s = {req.x1[31], req.x1} - {req.x0[31], req.x0};
  end

  // One restoring division step and the final rounding checks.
  always_comb begin
    rem_sh = {rem, num[64]};
    diff   = {1'b0, rem_sh} - {2'b00, dx};
    qbig   = (num[64:35] != '0) || (num[34] && num[33:0] != '0);
    r      = neg ? ({{5{y0[31]}}, y0} - {2'b00, num[34:0]})
                 : ({{5{y0[31]}}, y0} + {2'b00, num[34:0]});
  end

  // Sequencer: 32 multiply steps, 65 divide steps, one result step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (start) begin
            mcand  <= {32'd0, dy_s[32] ? 32'(-dy_s) : dy_s[31:0]};
            mplier <= t_s[32] ? 32'(-t_s) : t_s[31:0];
            dx     <= dx_s[31:0];
            // Seeding with half the divisor adds the rounding term for free.
            num    <= {34'd0, dx_s[31:1]};
            y0     <= req.y0;
            neg    <= dy_s[32] ^ t_s[32];
            cnt    <= '0;
            state  <= A_MUL;
          end
        end
        A_MUL: begin
          if (mplier[0]) begin
            num <= num + {1'b0, mcand};
          end
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
          cnt    <= (cnt == 7'd31) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd31) begin
            rem   <= '0;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          if (!diff[33]) begin
            rem <= diff[31:0];
          end else begin
            rem <= rem_sh[31:0];
          end
          num <= {num[63:0], ~diff[33]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd64) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          done <= 1'b1;
          if (qbig) begin
            sat <= 1'b1;
            y   <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else if (r > R_MAX) begin
            sat <= 1'b1;
            y   <= 32'sh7FFF_FFFF;
          end else if (r < R_MIN) begin
            sat <= 1'b1;
            y   <= 32'sh8000_0000;
          end else begin
            sat <= 1'b0;
            y   <= r[31:0];
          end
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  // A finished evaluation always comes from the result step.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == A_FIN)
    else $error("done without a result step");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == A_DIV) |-> cnt <= 7'd64)
    else $error("divide step count overran");
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (state == A_MUL) |-> cnt <= 7'd31)
    else $error("multiply step count overran");

endmodule

### rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a sorted point table held in a row of cells.
//
// Each transaction walks the row of MAX_POINTS cells one cell per cycle, so
// clear, insert, exact-hit and too-few queries end when the token returns. A
// query that must interpolate or extrapolate then runs the line evaluation
// unit: 32 multiply steps, 65 divide steps and one result step. One
// transaction is in work at a time; the next is taken while the previous
// result still waits at the output.
// Results use signed Q16.16 and saturate with status 4.
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  pli_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output pli_pkg::result_t result
);
  import pli_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ARITH, S_DONE} state_t;

  state_t     state;
  logic [CW-1:0] count;
  result_t    pend;
  result_t    scan_res;
  tok_t       tok [MAX_POINTS+1];
  tok_t       last;

  logic               a_start;
  arith_req_t         a_req;
  logic               a_done;
  logic               a_sat;
  logic signed [31:0] a_y;

  assign item_stall = (state != S_IDLE);
  assign last       = tok[MAX_POINTS];

  // Row of cells.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    pli_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Segment handed to the evaluation unit when the token comes back.
  always_comb begin
    a_req.x0 = last.ax;
    a_req.y0 = last.ay;
    a_req.x1 = last.bx;
    a_req.y1 = last.by;
    a_req.x  = last.x;
    a_start  = (state == S_SCAN) && last.valid && (last.op == OP_QUERY) &&
               !last.found && (count >= CW'(2));
  end

  // Outcome of a returned token that needs no line evaluation.
  always_comb begin
    scan_res.status    = ST_OK;
    scan_res.y_result  = '0;
    scan_res.exact_hit = 1'b0;
    case (last.op)
      OP_INSERT: begin
        if (last.found) begin
          scan_res.status = ST_DUPLICATE;
        end else if (!last.modify) begin
          scan_res.status = ST_FULL;
        end
      end
      OP_QUERY: begin
        if (last.found) begin
          scan_res.y_result  = last.fy;
          scan_res.exact_hit = 1'b1;
        end else if (count < CW'(2)) begin
          scan_res.status = ST_TOO_FEW;
        end
      end
      default: begin
      end
    endcase
  end

  pli_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (a_start),
    .req   (a_req),
    .done  (a_done),
    .sat   (a_sat),
    .y     (a_y)
  );

  // Control: inject the token, collect the outcome, hand out the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= (state == S_IDLE) && item_valid;
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // Token payload captured with the accepted transaction.
          tok[0].op      <= item.operation;
          tok[0].x       <= item.x_value;
          tok[0].y       <= item.y_value;
          tok[0].pending <= (item.operation == OP_INSERT);
          tok[0].modify  <= (count < CW'(MAX_POINTS));
          tok[0].found   <= 1'b0;
          tok[0].fy      <= '0;
          tok[0].ax      <= '0;
          tok[0].ay      <= '0;
          tok[0].bx      <= '0;
          tok[0].by      <= '0;
          tok[0].seen    <= 2'd0;
          tok[0].locked  <= 1'b0;
          if (item_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last.valid) begin
            pend  <= scan_res;
            state <= a_start ? S_ARITH : S_DONE;
            if (last.op == OP_CLEAR) begin
              count <= '0;
            end else if (last.op == OP_INSERT && !last.found && last.modify) begin
              count <= count + CW'(1);
            end
          end
        end
        S_ARITH: begin
          if (a_done) begin
            pend.status   <= a_sat ? ST_SATURATED : ST_OK;
            pend.y_result <= a_y;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= pend;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above table size");
  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> state == S_SCAN)
    else $error("token returned outside a scan");
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.exact_hit) |-> result.status == ST_OK)
    else $error("exact hit with a non-ok status");

endmodule
